// ===== hw/rtl/sdnb_pkg.sv =====
// Shared constants, codes and control types of the SD native bus card model.
package sdnb_pkg;

    localparam int STORE_BLOCKS = 2048;
    localparam int BLOCK_BYTES  = 512;
    localparam int BLK_AW       = (STORE_BLOCKS > 1) ? $clog2(STORE_BLOCKS) : 1;
    localparam int BYTE_AW      = $clog2(BLOCK_BYTES);
    localparam int STORE_AW     = BLK_AW + BYTE_AW;
    localparam int NIB_COUNT    = 2 * BLOCK_BYTES;
    localparam int CNT_W        = 12;

    localparam logic signed [CNT_W-1:0] NIB_END  = CNT_W'(NIB_COUNT);
    localparam logic signed [CNT_W-1:0] TAIL_END = CNT_W'(NIB_COUNT + 16);
    localparam logic signed [CNT_W-1:0] IDLE_END = CNT_W'(NIB_COUNT + 17);
    localparam logic signed [CNT_W-1:0] NIB_LAST = CNT_W'(NIB_COUNT - 1);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic CFG_PREAMBLE = 1'b0;
    localparam logic CFG_WAIT     = 1'b1;

    typedef struct packed {
        logic exec;
        logic fetch_done;
        logic clear_step;
    } dp_cmd_t;

    typedef struct packed {
        logic need_fetch;
        logic clear_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/sdnb_ctrl.sv =====
// Sequencer for the card model: clearing sweep, transaction handshakes and store fetch wait.
module sdnb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sdnb_pkg::dp_stat_t stat,
    output sdnb_pkg::dp_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && (!valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cmd.exec       = 1'b0;
        cmd.fetch_done = 1'b0;
        cmd.clear_step = 1'b0;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.exec   = 1'b1;
                    valid_next = 1'b1;
                    if (stat.need_fetch)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch_done = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hw/rtl/sdnb_datapath.sv =====
// Line register, command shifter, response sender, block streaming and the card store.
module sdnb_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sdnb_pkg::dp_cmd_t  cmd,
    output sdnb_pkg::dp_stat_t stat,
    input  logic [1:0]         in_mode,
    input  logic [7:0]         in_address,
    input  logic [15:0]        in_value,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wdata,
    output logic [7:0]         out_data
);

    localparam int CW = sdnb_pkg::CNT_W;

    localparam logic [1:0] PH_RECV  = 2'd0;
    localparam logic [1:0] PH_RESP  = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;
    localparam logic [1:0] PH_WRITE = 2'd3;

    localparam logic [7:0] CMD8_BYTE   = 8'h48;
    localparam logic [7:0] CMD17_BYTE  = 8'h51;
    localparam logic [7:0] CMD24_BYTE  = 8'h58;
    localparam logic [7:0] CMD41_BYTE  = 8'h69;
    localparam logic [7:0] CMD55_BYTE  = 8'h77;
    localparam logic [7:0] START_PAT   = 8'h40;

    // Card store and per-block written flags; unwritten blocks read as zero.
    logic [7:0] store_mem [sdnb_pkg::STORE_BLOCKS * sdnb_pkg::BLOCK_BYTES];
    logic       flag_mem  [sdnb_pkg::STORE_BLOCKS];

    logic [7:0]  pre_reg, wait_reg;
    logic        clk_reg, clk_next, cdir_reg, cdir_next, ddir_reg, ddir_next;
    logic        cmdl_reg, cmdl_next;
    logic [3:0]  dat_reg, dat_next;
    logic        pclk_reg, pclk_next, pcmd_reg, pcmd_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  bi_reg, bi_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  cb_reg [6];
    logic [2:0]  count_reg, count_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [2:0]  rbit_reg, rbit_next;
    logic [6:0]  crc_reg, crc_next;
    logic signed [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] blk_reg, blk_next;
    logic [3:0]  hi_reg, hi_next;
    logic        sel_reg, sel_next;
    logic [7:0]  out_reg, out_next;
    logic [sdnb_pkg::BLK_AW-1:0] clr_reg;

    logic        cb_we;
    logic [7:0]  new_shift, rbyte;
    logic        rbit_val, fb;
    logic        in_range, flag_q, st_re, st_we, fl_we, fl_val;
    logic [7:0]  st_q;
    logic [sdnb_pkg::STORE_AW-1:0] st_addr;
    logic [sdnb_pkg::BLK_AW-1:0]   fl_addr;
    logic        rise;
    logic [7:0]  mask;

    assign in_range = blk_reg < 32'(sdnb_pkg::STORE_BLOCKS);
    assign st_addr  = {blk_reg[sdnb_pkg::BLK_AW-1:0], cnt_reg[sdnb_pkg::BYTE_AW:1]};
    assign rise     = (pclk_reg != clk_reg) && clk_reg;
    assign mask     = in_value[15:8];
    assign new_shift = shift_reg | (cmdl_reg ? (8'h80 >> bi_reg) : 8'h00);

    assign stat.need_fetch = (in_mode == sdnb_pkg::MODE_TICK) && rise &&
                             (phase_reg == PH_READ) && !cnt_reg[CW-1];
    assign stat.clear_last = &clr_reg;
    assign out_data = out_reg;

    // Response byte for the current index; the CRC is folded in bit by bit as bytes go out.
    always_comb
    begin
        rbyte = 8'h00;
        case (cb_reg[0])
            CMD8_BYTE:
            begin
                case (ridx_reg)
                    3'd0:    rbyte = 8'd8;
                    3'd3:    rbyte = cb_reg[3];
                    3'd4:    rbyte = cb_reg[4];
                    3'd5:    rbyte = {crc_reg, 1'b1};
                    default: rbyte = 8'h00;
                endcase
            end
            CMD55_BYTE, CMD24_BYTE:
            begin
                case (ridx_reg)
                    3'd0:    rbyte = {2'b00, cb_reg[0][5:0]};
                    3'd5:    rbyte = {crc_reg, 1'b1};
                    default: rbyte = 8'h00;
                endcase
            end
            CMD41_BYTE:
            begin
                rbyte = (ridx_reg == 3'd0) ? 8'h3F : 8'hFF;
            end
            default:
            begin
                rbyte = 8'h00;
            end
        endcase
    end

    assign rbit_val = rbyte[3'd7 - rbit_reg];
    assign fb       = crc_reg[6] ^ rbit_val;

    always_comb
    begin
        clk_next   = clk_reg;
        cdir_next  = cdir_reg;
        ddir_next  = ddir_reg;
        cmdl_next  = cmdl_reg;
        dat_next   = dat_reg;
        pclk_next  = pclk_reg;
        pcmd_next  = pcmd_reg;
        phase_next = phase_reg;
        bi_next    = bi_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        ridx_next  = ridx_reg;
        rbit_next  = rbit_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        hi_next    = hi_reg;
        sel_next   = sel_reg;
        out_next   = out_reg;
        cb_we      = 1'b0;
        st_re      = 1'b0;
        st_we      = 1'b0;
        fl_we      = 1'b0;
        fl_val     = 1'b0;
        fl_addr    = blk_reg[sdnb_pkg::BLK_AW-1:0];

        if (cmd.clear_step)
        begin
            fl_we   = 1'b1;
            fl_addr = clr_reg;
        end

        if (cmd.fetch_done)
        begin
            if (in_range && flag_q)
            begin
                dat_next = sel_reg ? st_q[3:0] : st_q[7:4];
            end
            else
            begin
                dat_next = 4'h0;
            end
        end

        if (cmd.exec)
        begin
            out_next = 8'h00;
            if (in_mode == sdnb_pkg::MODE_WRITE)
            begin
                if (mask[0]) clk_next  = in_value[0];
                if (mask[1]) cdir_next = in_value[1];
                if (mask[2]) ddir_next = in_value[2];
                if (mask[3]) cmdl_next = in_value[3];
                if (|mask[7:4]) dat_next = in_value[7:4];
            end
            else if (in_mode == sdnb_pkg::MODE_READ)
            begin
                if (in_address == 8'h00)
                begin
                    out_next = {dat_reg, cmdl_reg, ddir_reg, cdir_reg, clk_reg};
                end
            end
            else if (in_mode == sdnb_pkg::MODE_TICK)
            begin
                if (rise)
                begin
                    case (phase_reg)
                        PH_RECV:
                        begin
                            if (bi_reg == 3'd7)
                            begin
                                cb_we      = 1'b1;
                                count_next = count_reg + 3'd1;
                                bi_next    = 3'd0;
                                shift_next = 8'h00;
                                if (count_reg == 3'd5)
                                begin
                                    ridx_next  = 3'd0;
                                    rbit_next  = 3'd0;
                                    crc_next   = 7'd0;
                                    phase_next = PH_RESP;
                                    if (cb_reg[0] == CMD17_BYTE)
                                    begin
                                        blk_next = {cb_reg[1], cb_reg[2], cb_reg[3], cb_reg[4]};
                                        cnt_next = -$signed({4'b0000, pre_reg}) - 12'sd1;
                                    end
                                    else if (cb_reg[0] == CMD24_BYTE)
                                    begin
                                        blk_next = {cb_reg[1], cb_reg[2], cb_reg[3], cb_reg[4]};
                                        cnt_next = -$signed({4'b0000, wait_reg});
                                    end
                                end
                            end
                            else if (count_reg == 3'd0 && bi_reg == 3'd1 &&
                                     new_shift != START_PAT)
                            begin
                                bi_next    = 3'd0;
                                shift_next = 8'h00;
                            end
                            else
                            begin
                                bi_next    = bi_reg + 3'd1;
                                shift_next = new_shift;
                            end
                        end
                        PH_RESP:
                        begin
                            cmdl_next = rbit_val;
                            if (ridx_reg < 3'd5)
                            begin
                                crc_next = {crc_reg[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
                            end
                            rbit_next = rbit_reg + 3'd1;
                            if (rbit_reg == 3'd7)
                            begin
                                ridx_next = ridx_reg + 3'd1;
                                if (ridx_reg == 3'd5)
                                begin
                                    ridx_next  = 3'd0;
                                    count_next = 3'd0;
                                    if (cb_reg[0] == CMD17_BYTE)
                                        phase_next = PH_READ;
                                    else if (cb_reg[0] == CMD24_BYTE)
                                        phase_next = PH_WRITE;
                                    else
                                        phase_next = PH_RECV;
                                end
                            end
                        end
                        PH_READ:
                        begin
                            if (cnt_reg < -12'sd1)
                            begin
                                dat_next = 4'hF;
                                cnt_next = cnt_reg + 12'sd1;
                            end
                            else if (cnt_reg == -12'sd1)
                            begin
                                dat_next = 4'h0;
                                cnt_next = 12'sd0;
                            end
                            else
                            begin
                                // The nibble is loaded in the fetch state, once the registered store read returns.
                                st_re    = 1'b1;
                                sel_next = cnt_reg[0];
                                cnt_next = cnt_reg + 12'sd1;
                                if (cnt_reg == sdnb_pkg::NIB_LAST)
                                    phase_next = PH_RECV;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg < 12'sd0)
                            begin
                                cnt_next = cnt_reg + 12'sd1;
                            end
                            else if (cnt_reg < sdnb_pkg::NIB_END)
                            begin
                                // Bytes go straight to the store; nothing reads it until the
                                // write phase ends, when the block's flag is set.
                                if (cnt_reg[0])
                                    st_we = in_range;
                                else
                                    hi_next = dat_reg;
                                cnt_next = cnt_reg + 12'sd1;
                            end
                            else if (cnt_reg < sdnb_pkg::TAIL_END)
                            begin
                                cnt_next = cnt_reg + 12'sd1;
                            end
                            else if (cnt_reg < sdnb_pkg::IDLE_END)
                            begin
                                dat_next = 4'hF;
                                cnt_next = cnt_reg + 12'sd1;
                            end
                            else
                            begin
                                fl_we      = in_range;
                                fl_val     = 1'b1;
                                phase_next = PH_RECV;
                            end
                        end
                    endcase
                end
                else if ((pclk_reg == clk_reg) && clk_reg && (pcmd_reg != cmdl_reg))
                begin
                    bi_next    = 3'd0;
                    shift_next = 8'h00;
                end
                pclk_next = clk_reg;
                pcmd_next = cmdl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_addr] <= {hi_reg, dat_reg};
        end
        if (st_re)
        begin
            st_q <= store_mem[st_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            flag_mem[fl_addr] <= fl_val;
        end
        flag_q <= flag_mem[blk_reg[sdnb_pkg::BLK_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cb_we)
        begin
            cb_reg[count_reg] <= new_shift;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        sel_reg <= sel_next;
        out_reg <= out_next;
        crc_reg <= crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg   <= 8'd99;
            wait_reg  <= 8'd9;
            clk_reg   <= 1'b0;
            cdir_reg  <= 1'b0;
            ddir_reg  <= 1'b0;
            cmdl_reg  <= 1'b0;
            dat_reg   <= 4'h0;
            pclk_reg  <= 1'b0;
            pcmd_reg  <= 1'b0;
            phase_reg <= PH_RECV;
            bi_reg    <= 3'd0;
            shift_reg <= 8'h00;
            count_reg <= 3'd0;
            ridx_reg  <= 3'd0;
            rbit_reg  <= 3'd0;
            cnt_reg   <= 12'sd0;
            blk_reg   <= 32'd0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == sdnb_pkg::CFG_PREAMBLE)
                    pre_reg <= cfg_wdata;
                else if (cfg_addr == sdnb_pkg::CFG_WAIT)
                    wait_reg <= cfg_wdata;
            end
            clk_reg   <= clk_next;
            cdir_reg  <= cdir_next;
            ddir_reg  <= ddir_next;
            cmdl_reg  <= cmdl_next;
            dat_reg   <= dat_next;
            pclk_reg  <= pclk_next;
            pcmd_reg  <= pcmd_next;
            phase_reg <= phase_next;
            bi_reg    <= bi_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            ridx_reg  <= ridx_next;
            rbit_reg  <= rbit_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
        end
    end

endmodule

// ===== hw/rtl/sd_card_native_bus_model.sv =====
// Top level of the card-side SD native bus model with its streaming and configuration ports.
//
// Each input transaction (tick, line register write or register read) gives exactly one
// result transaction. A tick that clocks out a data nibble of a read block passes through
// a fetch state, because the nibble comes from the card store's registered read port, and
// no item is taken during that fetch. After reset the block clears the 2048 per-block
// written flags of the card store and takes no items during that sweep; configuration
// writes are taken at any time. A result waits in an output register, so the next item is
// taken while it is still unclaimed as long as the result slot frees in the same cycle.
module sd_card_native_bus_model (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address [7:0], write_value [23:8]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data [7:0]
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    sdnb_pkg::dp_cmd_t  cmd;
    sdnb_pkg::dp_stat_t stat;

    sdnb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdnb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tuser),
        .in_address (s_tdata[7:0]),
        .in_value   (s_tdata[23:8]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .out_data   (m_tdata)
    );

endmodule

// ===== test/testbench.sv =====
// Testbench for the SD native bus card model: drives bit-banged host sequences and checks every result.
`timescale 1ns / 1ps

module testbench;

    localparam byte unsigned CMD_IF_COND   = 8;
    localparam byte unsigned CMD_APP       = 55;
    localparam byte unsigned CMD_OP_COND   = 41;
    localparam byte unsigned CMD_READ_BLK  = 17;
    localparam byte unsigned CMD_WRITE_BLK = 24;
    localparam byte unsigned CMD_GO_IDLE   = 0;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int PH_RECEIVE = 0;
    localparam int PH_RESPOND = 1;
    localparam int PH_READ    = 2;
    localparam int PH_WRITE   = 3;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1450;

    class card_scoreboard;
        bit [7:0] preamble_edges;
        bit [7:0] wait_edges;
        bit       l_clk, l_cdir, l_ddir, l_cmd;
        bit [3:0] l_dat;
        bit       last_clk, last_cmd;
        int       phase;
        bit [3:0] bit_pos;
        bit [7:0] shifter;
        bit [7:0] cmd_buf [6];
        int       cmd_cnt;
        bit [7:0] resp_buf [6];
        int       resp_idx, resp_bit;
        int       blk_cnt;
        bit [31:0] blk_num;
        bit [7:0] blk_data [sdnb_pkg::BLOCK_BYTES];
        bit [7:0] image [sdnb_pkg::STORE_BLOCKS*sdnb_pkg::BLOCK_BYTES];
        bit [7:0] pending [$];
        int       mismatches;

        function new();
            preamble_edges = 99;
            wait_edges = 9;
            phase = PH_RECEIVE;
            mismatches = 0;
        endfunction

        function void set_register(bit idx, bit [7:0] val);
            if (idx == sdnb_pkg::CFG_PREAMBLE)
                preamble_edges = val;
            else
                wait_edges = val;
        endfunction

        function bit [6:0] crc7(bit [7:0] b [6], int n);
            bit [6:0] c;
            bit fb;
            c = 0;
            for (int i = 0; i < n; i++)
                for (int k = 7; k >= 0; k--)
                begin
                    fb = c[6] ^ b[i][k];
                    c = {c[5:0], 1'b0};
                    if (fb)
                        c ^= 7'h09;
                end
            return c;
        endfunction

        function void seal();
            resp_buf[5] = {crc7(resp_buf, 5), 1'b1};
        endfunction

        function void clear_block();
            for (int i = 0; i < sdnb_pkg::BLOCK_BYTES; i++)
                blk_data[i] = 0;
        endfunction

        function void begin_response();
            bit [7:0] c;
            c = cmd_buf[0];
            resp_idx = 0;
            resp_bit = 0;
            phase = PH_RESPOND;
            for (int i = 0; i < 6; i++)
                resp_buf[i] = 0;
            if (c == (8'h40 | CMD_IF_COND))
            begin
                resp_buf[0] = CMD_IF_COND;
                resp_buf[3] = cmd_buf[3];
                resp_buf[4] = cmd_buf[4];
                seal();
            end
            else if (c == (8'h40 | CMD_APP))
            begin
                resp_buf[0] = CMD_APP;
                seal();
            end
            else if (c == (8'h40 | CMD_OP_COND))
            begin
                resp_buf[0] = 8'h3F;
                for (int i = 1; i < 6; i++)
                    resp_buf[i] = 8'hFF;
            end
            else if (c == (8'h40 | CMD_READ_BLK))
            begin
                blk_num = {cmd_buf[1], cmd_buf[2], cmd_buf[3], cmd_buf[4]};
                clear_block();
                if (blk_num < sdnb_pkg::STORE_BLOCKS)
                    for (int i = 0; i < sdnb_pkg::BLOCK_BYTES; i++)
                        blk_data[i] = image[blk_num*sdnb_pkg::BLOCK_BYTES + i];
                blk_cnt = -int'(preamble_edges) - 1;
            end
            else if (c == (8'h40 | CMD_WRITE_BLK))
            begin
                resp_buf[0] = CMD_WRITE_BLK;
                seal();
                blk_num = {cmd_buf[1], cmd_buf[2], cmd_buf[3], cmd_buf[4]};
                clear_block();
                blk_cnt = -int'(wait_edges);
            end
        endfunction

        function void clock_rise();
            bit [7:0] b;
            case (phase)
                PH_RECEIVE:
                begin
                    if (l_cmd)
                        shifter |= 8'h80 >> bit_pos[2:0];
                    bit_pos++;
                    if (bit_pos >= 8)
                    begin
                        if (cmd_cnt < 6)
                            cmd_buf[cmd_cnt++] = shifter;
                        bit_pos = 0;
                        shifter = 0;
                        if (cmd_cnt >= 6)
                            begin_response();
                    end
                    else if (cmd_cnt == 0 && bit_pos == 2 && shifter != 8'h40)
                    begin
                        bit_pos = 0;
                        shifter = 0;
                    end
                end
                PH_RESPOND:
                begin
                    l_cmd = resp_buf[resp_idx < 6 ? resp_idx : 5][7 - resp_bit];
                    if (++resp_bit >= 8)
                    begin
                        resp_bit = 0;
                        if (++resp_idx >= 6)
                        begin
                            resp_idx = 0;
                            if (cmd_buf[0] == (8'h40 | CMD_READ_BLK))
                                phase = PH_READ;
                            else if (cmd_buf[0] == (8'h40 | CMD_WRITE_BLK))
                                phase = PH_WRITE;
                            else
                                phase = PH_RECEIVE;
                            cmd_cnt = 0;
                        end
                    end
                end
                PH_READ:
                begin
                    if (blk_cnt < -1)
                    begin
                        l_dat = 4'hF;
                        blk_cnt++;
                    end
                    else if (blk_cnt == -1)
                    begin
                        l_dat = 4'h0;
                        blk_cnt = 0;
                    end
                    else
                    begin
                        b = blk_data[(blk_cnt >> 1) % sdnb_pkg::BLOCK_BYTES];
                        l_dat = blk_cnt[0] ? b[3:0] : b[7:4];
                        blk_cnt++;
                        if (blk_cnt >= 2*sdnb_pkg::BLOCK_BYTES)
                            phase = PH_RECEIVE;
                    end
                end
                default:
                begin
                    if (blk_cnt < 0)
                        blk_cnt++;
                    else if (blk_cnt < 2*sdnb_pkg::BLOCK_BYTES)
                    begin
                        if (blk_cnt[0])
                            blk_data[blk_cnt >> 1] |= {4'h0, l_dat};
                        else
                            blk_data[blk_cnt >> 1] |= {l_dat, 4'h0};
                        blk_cnt++;
                    end
                    else if (blk_cnt < 2*sdnb_pkg::BLOCK_BYTES + 16)
                        blk_cnt++;
                    else if (blk_cnt < 2*sdnb_pkg::BLOCK_BYTES + 17)
                    begin
                        l_dat = 4'hF;
                        blk_cnt++;
                    end
                    else
                    begin
                        if (blk_num < sdnb_pkg::STORE_BLOCKS)
                            for (int i = 0; i < sdnb_pkg::BLOCK_BYTES; i++)
                                image[blk_num*sdnb_pkg::BLOCK_BYTES + i] = blk_data[i];
                        phase = PH_RECEIVE;
                    end
                end
            endcase
        endfunction

        function void note_input(bit [1:0] mode, bit [7:0] addr, bit [15:0] val);
            bit [7:0] res;
            bit [7:0] mask;
            res = 0;
            mask = val[15:8];
            if (mode == sdnb_pkg::MODE_TICK)
            begin
                if (last_clk != l_clk)
                begin
                    if (l_clk)
                        clock_rise();
                end
                else if (l_clk && last_cmd != l_cmd)
                begin
                    bit_pos = 0;
                    shifter = 0;
                end
                last_clk = l_clk;
                last_cmd = l_cmd;
            end
            else if (mode == sdnb_pkg::MODE_WRITE)
            begin
                if (mask[0]) l_clk = val[0];
                if (mask[1]) l_cdir = val[1];
                if (mask[2]) l_ddir = val[2];
                if (mask[3]) l_cmd = val[3];
                if (mask[7:4] != 0) l_dat = val[7:4];
            end
            else if (mode == sdnb_pkg::MODE_READ && addr == 0)
                res = {l_dat, l_cmd, l_ddir, l_cdir, l_clk};
            pending = {pending, res};
        endfunction

        function void check_result(bit [7:0] got);
            bit [7:0] want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: read_data %02h", got);
                return;
            end
            want = pending.pop_front();
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("read_data mismatch: expected %02h, got %02h", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        cfg_we = 0;
    logic        cfg_addr = 0;
    logic [7:0]  cfg_wdata = 0;

    card_scoreboard sb = new();
    bit  quiet;
    int  rand_items;
    bit  in_hit, out_hit;
    logic [7:0] out_data;
    int  ready_wait;
    int  ready_draw;
    int  idle_cycles;

    sd_card_native_bus_model uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Handshakes are sampled half a period ahead, when every signal has settled.
    always @(negedge clk)
    begin
        in_hit = s_tvalid && s_tready;
        out_hit = m_tvalid && m_tready;
        out_data = m_tdata;
    end

    always @(posedge clk)
    begin
        if (out_hit)
            sb.check_result(out_data);
        if (rst_n)
        begin
            if (out_hit)
            begin
                ready_draw = quiet ? 0 : $urandom_range(0, 7);
                ready_wait <= ready_draw;
                m_tready <= (ready_draw == 0);
            end
            else if (!m_tready)
            begin
                if (ready_wait > 1)
                    ready_wait <= ready_wait - 1;
                else
                begin
                    ready_wait <= 0;
                    m_tready <= 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_hit || out_hit)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(bit [1:0] mode, bit [7:0] addr, bit [15:0] val);
        int gap;
        bit ok;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {val, addr};
        s_tuser <= mode;
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        sb.note_input(mode, addr, val);
        rand_items++;
    endtask

    // One host clock period: drop the clock while setting CMD and DAT, then raise it.
    task automatic host_edge(bit cmd, bit [3:0] dat);
        send_item(sdnb_pkg::MODE_WRITE, 0, {8'hF9, dat, cmd, 3'b000});
        send_item(sdnb_pkg::MODE_TICK, 8'($urandom), 16'($urandom));
        send_item(sdnb_pkg::MODE_WRITE, 0, {8'h01, 8'h01});
        send_item(sdnb_pkg::MODE_TICK, 8'($urandom), 16'($urandom));
        if ($urandom_range(0, 2) == 0)
            send_item(sdnb_pkg::MODE_READ, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
                      16'($urandom));
    endtask

    // Sends a command frame and clocks out its response; the run's item budget cuts it short.
    task automatic send_command(bit [7:0] first, bit [31:0] arg);
        bit [7:0] frame [6];
        int guard;
        frame[0] = first;
        frame[1] = arg[31:24];
        frame[2] = arg[23:16];
        frame[3] = arg[15:8];
        frame[4] = arg[7:0];
        frame[5] = {sb.crc7(frame, 5), 1'b1};
        for (int i = 0; i < 6; i++)
            for (int k = 7; k >= 0; k--)
                if (rand_items < ITEM_TARGET)
                    host_edge(frame[i][k], 4'($urandom));
        guard = 0;
        while (sb.phase == PH_RESPOND && guard < 64 && rand_items < ITEM_TARGET)
        begin
            host_edge(1'b1, 4'($urandom));
            guard++;
        end
        if (rand_items < ITEM_TARGET)
            host_edge(1'b1, 4'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(bit idx, bit [7:0] val);
        drain();
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_register(idx, val);
    endtask

    task automatic noise_item();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int pick;
        ready_wait = 0;
        idle_cycles = 0;
        rand_items = 0;
        quiet = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, unused mode, DAT mask behaviour and odd offsets.
        send_item(sdnb_pkg::MODE_READ, 0, 0);
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'hFFFF);
        send_item(sdnb_pkg::MODE_READ, 0, 16'hFFFF);
        send_item(sdnb_pkg::MODE_READ, 8'hFF, 16'hFFFF);
        send_item(MODE_SPARE, 8'hFF, 16'hFFFF);
        send_item(sdnb_pkg::MODE_TICK, 8'hFF, 16'hFFFF);
        send_item(sdnb_pkg::MODE_WRITE, 8'hFF, 16'h00F0);
        send_item(sdnb_pkg::MODE_READ, 0, 0);
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'h1000);
        send_item(sdnb_pkg::MODE_READ, 0, 0);
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'h80F0);
        send_item(sdnb_pkg::MODE_READ, 0, 0);
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'hFF00);
        send_item(sdnb_pkg::MODE_READ, 1, 0);
        send_item(sdnb_pkg::MODE_READ, 0, 0);
        // CMD toggles with the clock held high restart the shifter.
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'h0909);
        send_item(sdnb_pkg::MODE_TICK, 0, 0);
        send_item(sdnb_pkg::MODE_WRITE, 0, 16'h0800);
        send_item(sdnb_pkg::MODE_TICK, 0, 0);
        send_item(sdnb_pkg::MODE_READ, 0, 0);

        quiet = 1;
        write_register(sdnb_pkg::CFG_PREAMBLE, 8'd0);
        write_register(sdnb_pkg::CFG_WAIT, 8'd0);
        send_command(8'h40 | CMD_IF_COND, 32'h0000_01AA);
        quiet = 0;
        send_command(8'h40 | CMD_READ_BLK, 32'd5);

        while (rand_items < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_register(1'($urandom_range(0, 1)), 8'($urandom));
            if (pick < 2)
                repeat ($urandom_range(1, 12)) noise_item();
            else if (pick == 2)
                send_command(8'($urandom), $urandom);
            else if (pick == 3)
                send_command(8'h40 | CMD_IF_COND, $urandom);
            else if (pick == 4)
                send_command(8'h40 | CMD_APP, $urandom);
            else if (pick == 5)
                send_command(8'h40 | CMD_OP_COND, $urandom);
            else if (pick == 6)
                send_command(8'h40 | CMD_GO_IDLE, 0);
            else if (pick == 7)
                send_command(8'h40 | 8'($urandom_range(0, 63)), $urandom);
            else
            begin
                // A broken command: a few bits, then stray activity.
                repeat ($urandom_range(1, 20)) host_edge(1'($urandom), 4'($urandom));
                noise_item();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/sdnb_pkg.sv
hw/rtl/sdnb_ctrl.sv
hw/rtl/sdnb_datapath.sv
hw/rtl/sd_card_native_bus_model.sv
test/testbench.sv
